// ===== rtl/igl_pkg.sv =====
package igl_pkg;

    // fixed field widths of the ports
    localparam int OPER_W   = 32;
    localparam int RESULT_W = 63;

    // operation codes of the shared add/subtract unit
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // status of the sequencer as seen by the port logic
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [RESULT_W-1:0] result;
        logic                error;
    } igl_status_t;

endpackage

// ===== rtl/integer_gcd_lcm.sv =====
// gcd runs the binary gcd loop: strip common twos, make x odd, subtract and swap,
// then shift the common twos back; lcm adds a divide and a multiply on the same adder,
//   while an lcm with a zero operand skips the loop and answers with the error flag
// throughput: one item at a time; a new transfer is taken once the sequencer is idle
// a finished result waits in the output register while the next item runs
// reset: asynchronous active low, clears the sequencer and the output valid
module integer_gcd_lcm #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic signed [igl_pkg::OPER_W-1:0]    operand_a,
    input  logic signed [igl_pkg::OPER_W-1:0]    operand_b,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic        [igl_pkg::RESULT_W-1:0]  result,
    output logic                                 error
);
    import igl_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0]          a_low;
    logic [W-1:0]          b_low;
    logic [W-1:0]          mag_a;
    logic [W-1:0]          mag_b;
    logic                  start;
    logic                  take;
    igl_status_t           status;

    logic                  out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0]   result_reg, result_next;
    logic                  error_reg, error_next;

    // only the low OPERAND_WIDTH bits count, read as two's complement
    assign a_low = operand_a[W-1:0];
    assign b_low = operand_b[W-1:0];

    // magnitudes; the most negative value maps to 2^(W-1) without overflow
    assign mag_a = a_low[W-1] ? (~a_low + 1'b1) : a_low;
    assign mag_b = b_low[W-1] ? (~b_low + 1'b1) : b_low;

    // input transfer whenever the sequencer is idle
    assign in_stall = status.busy;
    assign start    = in_valid & ~in_stall;

    igl_core #(
        .W(W)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (command),
        .mag_a (mag_a),
        .mag_b (mag_b),
        .ack   (take),
        .status(status)
    );

    // result moves to the output register when it is empty or draining
    assign take = status.done & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        error_next     = error_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            result_next    = status.result;
            error_next     = status.error;
        end
        else if (out_valid_reg && !out_stall)
        begin
            // output transfer done, nothing new to show
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        error_reg  <= error_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign error     = error_reg;

endmodule

// ===== rtl/igl_addsub.sv =====
module igl_addsub #(
    parameter int WIDTH = 33
) (
    input  logic             op,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH:0]   sum
);
    import igl_pkg::*;

    // top bit is the borrow for a subtract, the carry for an add
    always_comb
    begin
        unique case (op)
            ALU_SUB: sum = {1'b0, a} - {1'b0, b};
            ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            default: sum = {1'b0, a} + {1'b0, b};
        endcase
    end

endmodule

// ===== rtl/igl_core.sv =====
module igl_core #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    input  logic [W-1:0]        mag_a,
    input  logic [W-1:0]        mag_b,
    input  logic                ack,
    output igl_pkg::igl_status_t status
);
    import igl_pkg::*;

    localparam int CW = $clog2(W);
    localparam int RW = RESULT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STRIP = 3'd1;
    localparam logic [2:0] ST_XODD  = 3'd2;
    localparam logic [2:0] ST_LOOP  = 3'd3;
    localparam logic [2:0] ST_FIX   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_MUL   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  ma_reg, ma_next;
    logic [W-1:0]  mb_reg, mb_next;
    logic [CW-1:0] shift_reg, shift_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          cmd_reg, cmd_next;
    logic [RW-1:0] res_reg, res_next;
    logic          err_reg, err_next;

    logic          alu_op;
    logic [W:0]    alu_a;
    logic [W:0]    alu_b;
    logic [W+1:0]  alu_sum;
    logic          borrow;
    logic [W:0]    mul_s;
    logic          cnt_last;

    igl_addsub #(
        .WIDTH(W + 1)
    ) u_addsub (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .sum(alu_sum)
    );

    // operand steering into the shared unit
    always_comb
    begin
        unique case (state_reg)
            ST_DIV:
            begin
                alu_op = ALU_SUB;
                alu_a  = {rem_reg, y_reg[W-1]};
                alu_b  = {1'b0, x_reg};
            end
            ST_MUL:
            begin
                alu_op = ALU_ADD;
                alu_a  = {1'b0, rem_reg};
                alu_b  = {1'b0, mb_reg};
            end
            default:
            begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, y_reg};
                alu_b  = {1'b0, x_reg};
            end
        endcase
    end

    assign borrow   = alu_sum[W+1];
    assign mul_s    = y_reg[0] ? alu_sum[W:0] : {1'b0, rem_reg};
    assign cnt_last = (cnt_reg == CW'(W - 1));

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rem_next   = rem_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        err_next   = err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next     = mag_a;
                    y_next     = mag_b;
                    ma_next    = mag_a;
                    mb_next    = mag_b;
                    cmd_next   = cmd;
                    shift_next = '0;
                    err_next   = 1'b0;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if (cmd_reg && (x_reg == '0 || y_reg == '0))
                begin
                    // lcm of a zero operand
                    res_next   = '0;
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (x_reg == '0)
                begin
                    x_next     = y_reg;
                    state_next = ST_FIX;
                end
                else if (y_reg == '0)
                begin
                    state_next = ST_FIX;
                end
                else if (!(x_reg[0] | y_reg[0]))
                begin
                    x_next     = x_reg >> 1;
                    y_next     = y_reg >> 1;
                    shift_next = shift_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_XODD;
                end
            end
            ST_XODD:
            begin
                if (!x_reg[0])
                    x_next = x_reg >> 1;
                else
                    state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (y_reg == '0)
                    state_next = ST_FIX;
                else if (!y_reg[0])
                    y_next = y_reg >> 1;
                else if (borrow)
                begin
                    // y below x: swap, subtract on the next pass
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else
                    y_next = alu_sum[W-1:0];
            end
            ST_FIX:
            begin
                if (shift_reg != '0)
                begin
                    x_next     = x_reg << 1;
                    shift_next = shift_reg - 1'b1;
                end
                else if (!cmd_reg)
                begin
                    res_next   = RW'(x_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    y_next     = ma_reg;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring divide of |a| by the gcd, quotient shifts into y
                if (borrow)
                    rem_next = {rem_reg[W-2:0], y_reg[W-1]};
                else
                    rem_next = alu_sum[W-1:0];
                y_next   = {y_reg[W-2:0], ~borrow};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add multiply of the quotient by |b|
                rem_next = mul_s[W:1];
                y_next   = {mul_s[0], y_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    res_next   = RW'({mul_s[W:1], mul_s[0], y_reg[W-1:1]});
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        rem_reg   <= rem_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
    end

    assign status.busy   = (state_reg != ST_IDLE);
    assign status.done   = (state_reg == ST_DONE);
    assign status.result = res_reg;
    assign status.error  = err_reg;

endmodule

// ===== bench/integer_gcd_lcm_tb.sv =====
`timescale 1ns / 100ps

module integer_gcd_lcm_tb;

    import igl_pkg::*;

    // operand width of the instance, the predictor follows it
    localparam int OPW = 32;

    // command codes of the block
    localparam logic CMD_GCD = 1'b0;
    localparam logic CMD_LCM = 1'b1;

    localparam int RANDOM_ITEMS = 1700;

    // worst case cycles for one lcm: binary gcd loop plus divide and multiply
    localparam int ITEM_CYCLES = 5 * OPW + 2 * OPW + 1 + 20;
    // longest receiver stall plus one full item, with margin, for the final drain
    localparam int DRAIN_LIMIT = 20 * (ITEM_CYCLES + 200);

    // slowest correct run: every item waits the longest sender gap, the longest
    // receiver stall and a full lcm; the timeout allows for that several times over
    localparam longint TIMEOUT_NS = 64'd60_000_000;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        logic                error;
    } answer_t;

    typedef struct {
        logic          cmd;
        logic [31:0]   a;
        logic [31:0]   b;
        logic          known;
        answer_t       answer;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [OPER_W-1:0]   operand_a;
    logic [OPER_W-1:0]   operand_b;
    logic                out_valid;
    logic                out_stall;
    logic [RESULT_W-1:0] result;
    logic                error;

    answer_t   expected_answers[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        burst_left = 0;

    integer_gcd_lcm #(
        .OPERAND_WIDTH(OPW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .error     (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // magnitude of the low OPW bits read as two's complement
    // the most negative value maps to 2^(OPW-1) since the math is 64 bits wide
    function automatic logic [63:0] magnitude(input logic [31:0] raw);
        logic [63:0] mask;
        logic [63:0] v;
        mask = (64'd1 << OPW) - 64'd1;
        v = {32'd0, raw} & mask;
        if (v[OPW-1])
        begin
            v = (~v + 64'd1) & mask;
        end
        return v;
    endfunction

    // gcd by euclid instead of the binary method, lcm as (|a| / gcd) * |b|
    // gcd(0, b) falls out as |b| and gcd(0, 0) as 0
    function automatic answer_t gcd_lcm_of(input logic cmd, input logic [31:0] a,
                                           input logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] rem;
        logic [63:0] prod;
        answer_t     ans;
        ma = magnitude(a);
        mb = magnitude(b);
        x = ma;
        y = mb;
        while (y != 64'd0)
        begin
            rem = x % y;
            x = y;
            y = rem;
        end
        ans.error = 1'b0;
        if (cmd == CMD_GCD)
        begin
            ans.result = x[RESULT_W-1:0];
        end
        else if (ma == 64'd0 || mb == 64'd0)
        begin
            // lcm with a zero operand is flagged
            ans.result = '0;
            ans.error = 1'b1;
        end
        else
        begin
            prod = (ma / x) * mb;
            ans.result = prod[RESULT_W-1:0];
        end
        return ans;
    endfunction

    task automatic add_row(input logic cmd, input logic [31:0] a, input logic [31:0] b,
                           input logic known, input logic [RESULT_W-1:0] res,
                           input logic err);
        stim_row_t row;
        row.cmd = cmd;
        row.a = a;
        row.b = b;
        row.known = known;
        row.answer.result = res;
        row.answer.error = err;
        directed_rows.push_back(row);
    endtask

    // one transfer on the input side; the sender runs in bursts with gaps
    // between them, and the gap lengths spread arrivals over every phase of
    // the block's busy time
    task automatic send_item(input logic cmd, input logic [31:0] a, input logic [31:0] b,
                             input answer_t want);
        int gap;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, 250);
            repeat (gap) @(posedge clk);
            // mostly short bursts, now and then a long one with no idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        expected_answers.push_back(want);
        burst_left--;
    endtask

    // operand classes that reach the corners: zero, powers of two (the most
    // negative value among them), small values of either sign, full random
    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9)) inside
            0: v = 32'd0;
            1: v = 32'd1 << $urandom_range(0, 31);
            2: v = 32'h8000_0000;
            3, 4:
            begin
                v = $urandom_range(1, 1000);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // receiver stalls on its own pattern: runs of stall and no stall with
    // random lengths, with long quiet stretches and the odd long stall that
    // holds a finished result while the next item is running
    initial
    begin
        int run;
        out_stall <= 1'b0;
        forever
        begin
            case ($urandom_range(0, 9)) inside
                0, 1, 2:
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(1, 4);
                end
                3:
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(20, 200);
                end
                4:
                begin
                    out_stall <= 1'b0;
                    run = $urandom_range(200, 2000);
                end
                default:
                begin
                    out_stall <= 1'b0;
                    run = $urandom_range(1, 60);
                end
            endcase
            repeat (run) @(posedge clk);
        end
    end

    // result side: each transfer is checked against the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %0d error %0b", result, error));
            end
            else
            begin
                want = expected_answers.pop_front();
                if (result !== want.result)
                begin
                    report_mismatch($sformatf("result %0d, want %0d", result, want.result));
                end
                if (error !== want.error)
                begin
                    report_mismatch($sformatf("error %0b, want %0b", error, want.error));
                end
            end
        end
    end

    initial
    begin
        logic        cmd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] factor;
        answer_t     want;
        int          waited;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        command   <= CMD_GCD;
        operand_a <= '0;
        operand_b <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: answers typed in where they are plain, the rest predicted
        // gcd with zeros: both zero, and one zero giving the other magnitude
        add_row(CMD_GCD, 32'd0, 32'd0, 1'b1, 63'd0, 1'b0);
        add_row(CMD_GCD, 32'd0, -32'd12, 1'b1, 63'd12, 1'b0);
        add_row(CMD_GCD, 32'h8000_0000, 32'd0, 1'b1, 63'h8000_0000, 1'b0);
        // lcm with a zero operand flags an error
        add_row(CMD_LCM, 32'd0, 32'd5, 1'b1, 63'd0, 1'b1);
        add_row(CMD_LCM, 32'd7, 32'd0, 1'b1, 63'd0, 1'b1);
        add_row(CMD_LCM, 32'd0, 32'd0, 1'b1, 63'd0, 1'b1);
        add_row(CMD_LCM, 32'h8000_0000, 32'd0, 1'b1, 63'd0, 1'b1);
        // most negative operand has magnitude 2^31 without overflow
        add_row(CMD_GCD, 32'h8000_0000, 32'h8000_0000, 1'b1, 63'h8000_0000, 1'b0);
        add_row(CMD_LCM, 32'h8000_0000, 32'h8000_0000, 1'b1, 63'h8000_0000, 1'b0);
        // largest possible lcm: 2^31 * (2^31 - 1)
        add_row(CMD_LCM, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 63'h3FFF_FFFF_8000_0000, 1'b0);
        add_row(CMD_GCD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 63'h7FFF_FFFF, 1'b0);
        add_row(CMD_GCD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 63'd1, 1'b0);
        add_row(CMD_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 63'd1, 1'b0);
        add_row(CMD_LCM, 32'hFFFF_FFFF, 32'd1, 1'b1, 63'd1, 1'b0);
        add_row(CMD_GCD, 32'd1, 32'h8000_0000, 1'b1, 63'd1, 1'b0);
        add_row(CMD_LCM, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0, '0, 1'b0);
        add_row(CMD_LCM, 32'h8000_0001, 32'h8000_0002, 1'b0, '0, 1'b0);
        add_row(CMD_GCD, 32'd12, 32'd18, 1'b0, '0, 1'b0);
        add_row(CMD_LCM, -32'd4, 32'd6, 1'b0, '0, 1'b0);
        add_row(CMD_GCD, 32'h8000_0000, 32'h4000_0000, 1'b0, '0, 1'b0);
        add_row(CMD_LCM, 32'h0001_0000, -32'd96, 1'b0, '0, 1'b0);
        add_row(CMD_GCD, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0, 1'b0);
        add_row(CMD_LCM, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0, 1'b0);

        foreach (directed_rows[i])
        begin
            want = directed_rows[i].known ? directed_rows[i].answer
                 : gcd_lcm_of(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b);
            send_item(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b, want);
        end

        // random part: a share of pairs built on a common factor so that gcd and
        // lcm are nontrivial, the rest drawn from the operand classes
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_GCD : CMD_LCM;
            if ($urandom_range(0, 9) < 4)
            begin
                // 4095 * (2^19 - 1) stays below 2^31
                factor = $urandom_range(1, 4095);
                a = factor * $urandom_range(0, 524287);
                b = factor * $urandom_range(0, 524287);
                if ($urandom_range(0, 1) == 1)
                begin
                    a = -a;
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    b = -b;
                end
            end
            else
            begin
                a = random_operand();
                b = random_operand();
            end
            send_item(cmd, a, b, gcd_lcm_of(cmd, a, b));
        end
        in_valid <= 1'b0;

        // drain: wait for the outstanding results, bounded
        waited = 0;
        while (expected_answers.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_answers.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
        end
        // catch any stray result after the last one expected
        repeat (ITEM_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/igl_pkg.sv
rtl/igl_addsub.sv
rtl/igl_core.sv
rtl/integer_gcd_lcm.sv
bench/integer_gcd_lcm_tb.sv
